FILE: rtl/gfau_pkg.sv
// Shared types, constants and constant tables for the GF(2^8) arithmetic unit.
// Field polynomial x^8+x^4+x^3+x^2+1; no dependencies.
package gfau_pkg;

   localparam int GF_WIDTH = 8;
   localparam int GF_ORDER = 255;
   localparam int NUM_CELLS = GF_WIDTH;
   localparam logic [GF_WIDTH-1:0] GF_POLY_LOW = 8'h1d;

   typedef enum logic [2:0] {
      CMD_ADD  = 3'd0,
      CMD_SUB  = 3'd1,
      CMD_MUL  = 3'd2,
      CMD_DIV  = 3'd3,
      CMD_ALOG = 3'd4
   } gfau_cmd_type;

   // Word carried along the cell chain. Each cell consumes the low bit of y,
   // adds m into acc when it is set, and doubles m in the field.
   typedef struct packed {
      logic [GF_WIDTH-1:0] acc;
      logic [GF_WIDTH-1:0] m;
      logic [GF_WIDTH-1:0] y;
      logic                err;
   } gfau_word_type;

   typedef logic [GF_WIDTH-1:0] gf_table_type [256];

   function automatic logic [GF_WIDTH-1:0] gf_xtime(input logic [GF_WIDTH-1:0] v);
      if (v[GF_WIDTH-1]) begin
         return {v[GF_WIDTH-2:0], 1'b0} ^ GF_POLY_LOW;
      end
      return {v[GF_WIDTH-2:0], 1'b0};
   endfunction

   // Powers of alpha = x; entry 255 is unused and holds zero.
   function automatic gf_table_type build_exp_table();
      gf_table_type        t;
      logic [GF_WIDTH-1:0] p;
      p = 8'd1;
      for (int e = 0; e < 256; e++) begin
         t[e] = (e < GF_ORDER) ? p : 8'd0;
         p = gf_xtime(p);
      end
      return t;
   endfunction

   // Multiplicative inverse of every nonzero element; zero maps to zero.
   function automatic gf_table_type build_inv_table();
      gf_table_type t;
      gf_table_type x;
      x = build_exp_table();
      for (int i = 0; i < 256; i++) begin
         t[i] = 8'd0;
      end
      for (int e = 0; e < GF_ORDER; e++) begin
         t[x[e]] = x[(GF_ORDER - e) % GF_ORDER];
      end
      return t;
   endfunction

   localparam gf_table_type EXP_TABLE = build_exp_table();
   localparam gf_table_type INV_TABLE = build_inv_table();

endpackage

FILE: rtl/gfau_front.sv
// Front stage of the GF(2^8) arithmetic unit: decodes the operation and loads
// the first word of the cell chain. Depends on gfau_pkg.
module gfau_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_cmd,
   input  logic [7:0]             req_a,
   input  logic [7:0]             req_b,
   output logic                   out_valid,
   input  logic                   out_ready,
   output gfau_pkg::gfau_word_type out_data
);
   import gfau_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   gfau_word_type word_ff;
   gfau_word_type word_in;
   logic          load;

   // Everything but multiply and divide is finished here: the result goes into
   // acc with y cleared, so the cells pass it along untouched.
   always_comb begin
      word_in = '0;
      case (gfau_cmd_type'(req_cmd))
         CMD_ADD, CMD_SUB: begin
            word_in.acc = req_a ^ req_b;
         end
         CMD_MUL: begin
            word_in.m = req_a;
            word_in.y = req_b;
         end
         CMD_DIV: begin
            if (req_b == 8'd0) begin
               word_in.err = 1'b1;
            end else begin
               word_in.m = req_a;
               word_in.y = INV_TABLE[req_b];
            end
         end
         CMD_ALOG: begin
            if (req_a == 8'(GF_ORDER)) begin
               word_in.err = 1'b1;
            end else begin
               word_in.acc = EXP_TABLE[req_a];
            end
         end
         default: begin
            word_in.err = 1'b1;
         end
      endcase
   end

   assign req_ready = !valid_ff || out_ready;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = word_ff;

endmodule

FILE: rtl/gfau_cell.sv
// One shift-and-add cell of the GF(2^8) multiplier chain: handles one bit of
// the multiplier and hands the word to its neighbor. Depends on gfau_pkg.
module gfau_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  gfau_pkg::gfau_word_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output gfau_pkg::gfau_word_type out_data
);
   import gfau_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   gfau_word_type word_ff;
   gfau_word_type word_in;

   always_comb begin
      word_in     = in_data;
      word_in.acc = in_data.y[0] ? (in_data.acc ^ in_data.m) : in_data.acc;
      word_in.m   = gf_xtime(in_data.m);
      word_in.y   = {1'b0, in_data.y[GF_WIDTH-1:1]};
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = word_ff;

endmodule

FILE: rtl/gf256_arithmetic_unit.sv
// Top level of the GF(2^8) arithmetic unit (polynomial 0x11d): a decode stage
// followed by a chain of multiply cells. Depends on gfau_pkg, gfau_front, gfau_cell.
//
//   Channel   Ports                                   Direction
//   request   req_valid, req_ready, req_cmd/a/b       in
//   response  rsp_valid, rsp_ready, rsp_result/error  out
//
// One request is accepted per cycle while req_ready is high; each passes
// through the decode stage and then one cell per multiplier bit to its response.
// Reset is synchronous and clears only the valid bit of every stage.
// Each stage holds its word while the stage after it is full and stalled, and
// an empty stage still takes a new word, so bubbles close up under a stall.
module gf256_arithmetic_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_a,
   input  logic [7:0] req_b,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_result,
   output logic       rsp_error
);
   import gfau_pkg::*;

   // Stage 0 is the decode stage; stages 1 to NUM_CELLS are the cells.
   logic          stage_valid [NUM_CELLS+1];
   logic          stage_ready [NUM_CELLS+1];
   gfau_word_type stage_data  [NUM_CELLS+1];

   gfau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .req_a     (req_a),
      .req_b     (req_b),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   // Each cell multiplies in one bit of y, low bit first, so after the last
   // cell acc holds the full reduced product.
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      gfau_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   assign stage_ready[NUM_CELLS] = rsp_ready;

   assign rsp_valid  = stage_valid[NUM_CELLS];
   assign rsp_result = stage_data[NUM_CELLS].acc;
   assign rsp_error  = stage_data[NUM_CELLS].err;

   // An error response always carries a zero result.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_result == 8'd0)
      else $error("error response with nonzero result");

   // All multiplier bits have been consumed by the time a word leaves the chain.
   a_y_consumed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> stage_data[NUM_CELLS].y == 8'd0)
      else $error("multiplier bits left at the end of the chain");

   // A flagged word enters the chain with nothing to accumulate.
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      stage_valid[0] && stage_data[0].err |->
         stage_data[0].acc == 8'd0 && stage_data[0].y == 8'd0)
      else $error("error word carries data into the cells");

   // An accepted request is held in the decode stage in the next cycle.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> stage_valid[0])
      else $error("accepted request lost at the decode stage");

   // The decode stage only refuses a request while it is full and stalled.
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> stage_valid[0] && !stage_ready[0])
      else $error("request refused with room in the decode stage");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for gf256_arithmetic_unit, the GF(2^8) unit over 0x11d.
// Needs only gfau_pkg for the command codes and the field constants; the expected
// responses come from a field model written here.
`timescale 1ns / 100ps

module tb;
   import gfau_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 11;
   // The pipeline is nine stages deep, so the settle wait after the last response
   // is ample time for a stray response to show up.
   localparam int SETTLE_CYCLES = 20;
   // A receiver hold-off far longer than the pipeline depth, so that the unit
   // fills up completely and has to drop req_ready.
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int MAX_REPORTED = 10;
   // Many times the slowest legal run of this stimulus.
   localparam int TIMEOUT_NS = 2_400_000;

   // Selector values that the package leaves undefined. The unit must flag them.
   localparam logic [2:0] CMD_FIRST_UNDEFINED = 3'd5;
   localparam logic [2:0] CMD_LAST_UNDEFINED = 3'd7;

   localparam logic [7:0] ALPHA = 8'h02;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] a;
      logic [7:0] b;
   } gf_request_type;

   typedef struct packed {
      logic [7:0] result;
      logic       error;
   } gf_response_type;

   // Each awaited response keeps the request that caused it, for the report.
   typedef struct packed {
      gf_request_type  req;
      gf_response_type rsp;
   } gf_outcome_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_cmd = CMD_ADD;
   logic [7:0] req_a = 8'h00;
   logic [7:0] req_b = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_result;
   logic       rsp_error;

   gf_request_type pending_requests[$];
   gf_outcome_type awaited_responses[$];
   gf_request_type offered;

   // Idling percentages, changed by the stimulus block on falling edges only.
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   // The stimulus block bumps hold_arms to start a long hold-off; the counter
   // process notices the change and loads hold_left itself.
   int hold_arms = 0;
   int hold_arms_seen = 0;

   int mismatch_count = 0;
   int checked_count = 0;
   int error_count = 0;
   int accepted_by_cmd[8];
   int backpressure_cycles = 0;

   gf256_arithmetic_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_a      (req_a),
      .req_b      (req_b),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result),
      .rsp_error  (rsp_error)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Field model
   // ------------------------------------------------------------------------

   // Shift-and-add product: the multiplicand is doubled in the field at every
   // step and folded back with the low byte of the polynomial when it overflows.
   function automatic logic [7:0] gf_times(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] acc;
      logic [7:0] m;
      acc = 8'h00;
      m = x;
      for (int i = 0; i < GF_WIDTH; i++) begin
         if (y[i]) begin
            acc = acc ^ m;
         end
         m = m[7] ? ({m[6:0], 1'b0} ^ GF_POLY_LOW) : {m[6:0], 1'b0};
      end
      return acc;
   endfunction

   function automatic logic [7:0] alpha_power(input logic [7:0] e);
      logic [7:0] r;
      r = 8'h01;
      for (int i = 0; i < e; i++) begin
         r = gf_times(r, ALPHA);
      end
      return r;
   endfunction

   // The multiplicative group has order 255, so v^254 is the inverse of v.
   function automatic logic [7:0] gf_inverse(input logic [7:0] v);
      logic [7:0] r;
      r = 8'h01;
      for (int i = 0; i < GF_ORDER - 1; i++) begin
         r = gf_times(r, v);
      end
      return r;
   endfunction

   function automatic gf_response_type predict_response(input gf_request_type req);
      gf_response_type rsp;
      rsp.result = 8'h00;
      rsp.error = 1'b0;
      case (req.cmd)
         CMD_ADD, CMD_SUB: begin
            rsp.result = req.a ^ req.b;
         end
         CMD_MUL: begin
            rsp.result = gf_times(req.a, req.b);
         end
         CMD_DIV: begin
            // A zero divisor is an error; a zero dividend simply gives zero.
            if (req.b == 8'h00) begin
               rsp.error = 1'b1;
            end else begin
               rsp.result = gf_times(req.a, gf_inverse(req.b));
            end
         end
         CMD_ALOG: begin
            // Exponents run 0 to 254; 255 has no place in the group.
            if (req.a >= GF_ORDER) begin
               rsp.error = 1'b1;
            end else begin
               rsp.result = alpha_power(req.a);
            end
         end
         default: begin
            rsp.error = 1'b1;
         end
      endcase
      return rsp;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------

   // At each rising edge the driver first records a request accepted at this
   // edge, then decides what to offer next. Valid is only lowered when the
   // current request has gone, and each port gets one assignment per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_responses.push_back({offered, predict_response(offered)});
            accepted_by_cmd[offered.cmd]++;
         end
         if (req_valid && !req_ready) begin
            backpressure_cycles++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_cmd <= offered.cmd;
               req_a <= offered.a;
               req_b <= offered.b;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls plus one long hold-off
   // ------------------------------------------------------------------------

   // The hold-off is loaded and counted down here; the stimulus block only arms it.
   always @(posedge clock) begin
      if (hold_arms != hold_arms_seen) begin
         hold_arms_seen <= hold_arms;
         hold_left <= LONG_HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      gf_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         checked_count++;
         if (rsp_error) begin
            error_count++;
         end
         if (awaited_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED) begin
               $display("%0t: response with nothing awaited: result %02h error %0b",
                        $realtime, rsp_result, rsp_error);
            end
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_result !== want.rsp.result || rsp_error !== want.rsp.error) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED) begin
                  $display("%0t: cmd %0d a %02h b %02h: awaited result %02h error %0b, got %02h %0b",
                           $realtime, want.req.cmd, want.req.a, want.req.b,
                           want.rsp.result, want.rsp.error, rsp_result, rsp_error);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   task automatic queue_request(input logic [2:0] cmd, input logic [7:0] a,
                                input logic [7:0] b);
      pending_requests.push_back({cmd, a, b});
   endtask

   // Operands lean toward the corners of the field now and then, so that
   // zero divisors and the out-of-range exponent keep coming up.
   function automatic logic [7:0] pick_operand();
      logic [7:0] corners[4];
      corners = '{8'h00, 8'h01, 8'h80, 8'hff};
      if ($urandom_range(0, 7) == 0) begin
         return corners[$urandom_range(0, 3)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_random(input int count);
      logic [2:0] cmd;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 4) begin
            cmd = 3'($urandom_range(CMD_FIRST_UNDEFINED, CMD_LAST_UNDEFINED));
         end else begin
            cmd = 3'($urandom_range(CMD_ADD, CMD_ALOG));
         end
         queue_request(cmd, pick_operand(), pick_operand());
      end
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
   endtask

   task automatic wait_queue_empty();
      while (pending_requests.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed requests, sent back to back.
      set_idling(0, 0);
      queue_request(CMD_ADD, 8'h00, 8'h00);
      queue_request(CMD_ADD, 8'hff, 8'hff);
      queue_request(CMD_ADD, 8'hff, 8'h00);
      queue_request(CMD_SUB, 8'ha5, 8'h5a);
      queue_request(CMD_MUL, 8'hff, 8'hff);
      queue_request(CMD_MUL, 8'h00, 8'hff);
      queue_request(CMD_MUL, 8'h01, 8'h53);
      queue_request(CMD_MUL, 8'h80, ALPHA);
      queue_request(CMD_DIV, 8'h00, 8'h37);   // zero dividend
      queue_request(CMD_DIV, 8'h9c, 8'h00);   // zero divisor
      queue_request(CMD_DIV, 8'h00, 8'h00);
      queue_request(CMD_DIV, 8'hff, 8'hff);
      queue_request(CMD_DIV, 8'h01, 8'hff);
      queue_request(CMD_DIV, 8'h01, 8'h80);
      queue_request(CMD_ALOG, 8'h00, 8'hff);
      queue_request(CMD_ALOG, 8'h01, 8'h00);
      queue_request(CMD_ALOG, 8'h07, 8'h00);
      queue_request(CMD_ALOG, 8'h08, 8'h00);  // first power that needs reduction
      queue_request(CMD_ALOG, 8'hfe, 8'h00);  // largest legal exponent
      queue_request(CMD_ALOG, 8'hff, 8'h00);  // exponent out of range
      for (int c = CMD_FIRST_UNDEFINED; c <= CMD_LAST_UNDEFINED; c++) begin
         queue_request(3'(c), 8'h3c, 8'hc3);
      end
      wait_queue_empty();

      // Random traffic through the four idling patterns.
      queue_random(450);
      wait_queue_empty();
      set_idling(60, 0);
      queue_random(450);
      wait_queue_empty();
      set_idling(0, 60);
      queue_random(450);
      wait_queue_empty();
      set_idling(22, 22);
      queue_random(330);
      wait_queue_empty();

      // The receiver holds off while the sender keeps offering, so the pipeline
      // fills and back-pressure reaches the request side.
      set_idling(0, 0);
      hold_arms++;
      queue_random(80);
      wait_queue_empty();

      // Let the last request go, then drain every awaited response.
      while (req_valid || awaited_responses.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_responses.size() != 0) begin
         mismatch_count += awaited_responses.size();
      end

      $display("Checked %0d responses (%0d flagged as errors); requests per command 0..7:",
               checked_count, error_count);
      $display("  %0d %0d %0d %0d %0d %0d %0d %0d, %0d cycles of request back-pressure.",
               accepted_by_cmd[0], accepted_by_cmd[1], accepted_by_cmd[2], accepted_by_cmd[3],
               accepted_by_cmd[4], accepted_by_cmd[5], accepted_by_cmd[6], accepted_by_cmd[7],
               backpressure_cycles);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d requests pending and %0d responses awaited",
               pending_requests.size(), awaited_responses.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
